// ===== rtl/core/time_series_gap_filler_macros.svh =====
// Assertion helpers shared by the gap filler RTL
`ifndef TIME_SERIES_GAP_FILLER_MACROS_SVH
`define TIME_SERIES_GAP_FILLER_MACROS_SVH

// same-cycle implication, clocked on aclk, off while in reset
`define TSGF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSGF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tsgf_pkg.sv =====
package tsgf_pkg;

    localparam int TIME_W    = 40;
    localparam int VAL_W     = 32;
    localparam int DIFF_W    = 50;   // signed grid offsets, covers 64 periods
    localparam int MAG_W     = 32;   // |sample_value - previous_value|
    localparam int PMUL_W    = MAG_W + TIME_W;
    localparam int PROD_W    = 78;   // |dv| * 63 periods
    localparam int QSAT_BITS = 33;
    localparam int Q_W       = QSAT_BITS + 1;
    localparam int SUM_W     = 36;
    localparam int MAX_FILL  = 63;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] FILL_ORIG    = 2'd0;
    localparam logic [1:0] FILL_INTERP  = 2'd1;
    localparam logic [1:0] FILL_MISSING = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_UNEVEN  = 2'd1;
    localparam logic [1:0] STAT_LIMIT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERP    = 2'd2;

    localparam logic [TIME_W-1:0] PERIOD_RST    = 40'd86400;
    localparam logic [TIME_W-1:0] TOLERANCE_RST = 40'd8640;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GAP,
        ST_COUNT,
        ST_MUL,
        ST_SAT,
        ST_DIV,
        ST_FILL_OUT,
        ST_LAST
    } tsgf_state_t;

    typedef struct packed {
        logic [TIME_W-1:0]       sample_time;
        logic signed [VAL_W-1:0] sample_value;
        logic                    restart;
    } tsgf_in_t;

    typedef struct packed {
        logic [TIME_W-1:0]       out_time;
        logic signed [VAL_W-1:0] out_value;
        logic [1:0]              fill_kind;
        logic [1:0]              status;
        logic                    last;
    } tsgf_out_t;

endpackage

// ===== rtl/core/time_series_gap_filler.sv =====
// Time series gap filler. Samples come in on s_*, results leave on m_*, one sample
// at a time (s_ready is high only while the block is idle, but a finished result may
// still wait in the output register). A first sample or a restart passes straight
// through to the output. Otherwise a sample is checked against the grid; when a gap
// is found, the run of fills is counted, and in interpolate mode a serial shift-add
// multiply follows, then for each fill the restoring divider (one quotient bit a
// cycle) runs, unless the quotient saturates, before the result is emitted. Without
// interpolation or for a zero span, multiply and divide are skipped. The fill value
// is previous_value + (dv * elapsed) / span, truncated toward zero and saturated.
`include "time_series_gap_filler_macros.svh"

module time_series_gap_filler
    import tsgf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tsgf_in_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tsgf_out_t            m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_wr_data
);

    tsgf_state_t state_reg, state_next;

    logic [TIME_W-1:0]        period_reg, tol_reg;
    logic                     interp_reg;

    logic [TIME_W-1:0]        t_reg, t_next;
    logic signed [VAL_W-1:0]  v_reg, v_next;
    logic [TIME_W-1:0]        pt_reg, pt_next;
    logic signed [VAL_W-1:0]  pv_reg, pv_next;
    logic                     have_prev_reg, have_prev_next;

    logic signed [DIFF_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0]         fill_total_reg, fill_total_next;
    logic [CNT_W-1:0]         fill_idx_reg, fill_idx_next;
    logic [1:0]               status_reg, status_next;
    logic [TIME_W-1:0]        gtime_reg, gtime_next;
    logic [TIME_W-1:0]        span_mag_reg, span_mag_next;
    logic                     span_zero_reg, span_zero_next;
    logic                     neg_reg, neg_next;
    logic [MAG_W-1:0]         mplier_reg, mplier_next;
    logic [PMUL_W-1:0]        pmul_reg, pmul_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [TIME_W-1:0]        rem_reg, rem_next;
    logic [QSAT_BITS-1:0]     div_lo_reg, div_lo_next;
    logic [Q_W-1:0]           q_reg, q_next;
    logic [CNT_W-1:0]         step_reg, step_next;

    logic                     m_valid_reg, m_valid_next;
    tsgf_out_t                m_data_reg, m_data_next;

    logic                     slot_free, out_load;
    logic signed [DIFF_W-1:0] tol_s, dn, span_s, d_acc;
    logic signed [VAL_W:0]    dv;
    logic [PMUL_W-1:0]        pmul_step;
    logic [TIME_W:0]          trial;
    logic signed [SUM_W-1:0]  fill_sum;
    logic signed [VAL_W-1:0]  fill_val;
    logic                     use_div;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign slot_free = !m_valid_reg || m_ready;
    assign tol_s     = $signed({{(DIFF_W-TIME_W){1'b0}}, tol_reg});
    assign use_div   = interp_reg && !span_zero_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RST;
            tol_reg    <= TOLERANCE_RST;
            interp_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PERIOD:    period_reg <= cfg_wr_data;
                CFG_TOLERANCE: tol_reg    <= cfg_wr_data;
                CFG_INTERP:    interp_reg <= cfg_wr_data[0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            have_prev_reg <= 1'b0;
            pt_reg        <= '0;
            pv_reg        <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            have_prev_reg <= have_prev_next;
            pt_reg        <= pt_next;
            pv_reg        <= pv_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        t_reg          <= t_next;
        v_reg          <= v_next;
        d_reg          <= d_next;
        fill_total_reg <= fill_total_next;
        fill_idx_reg   <= fill_idx_next;
        status_reg     <= status_next;
        gtime_reg      <= gtime_next;
        span_mag_reg   <= span_mag_next;
        span_zero_reg  <= span_zero_next;
        neg_reg        <= neg_next;
        mplier_reg     <= mplier_next;
        pmul_reg       <= pmul_next;
        prod_reg       <= prod_next;
        rem_reg        <= rem_next;
        div_lo_reg     <= div_lo_next;
        q_reg          <= q_next;
        step_reg       <= step_next;
        m_data_reg     <= m_data_next;
    end

    // shared datapath terms
    always_comb begin
        dn        = d_reg - $signed({{(DIFF_W-TIME_W){1'b0}}, period_reg});
        span_s    = $signed({{(DIFF_W-TIME_W){1'b0}}, t_reg})
                  - $signed({{(DIFF_W-TIME_W){1'b0}}, pt_reg});
        d_acc     = span_s - $signed({{(DIFF_W-TIME_W){1'b0}}, period_reg});
        dv        = $signed({v_reg[VAL_W-1], v_reg}) - $signed({pv_reg[VAL_W-1], pv_reg});
        pmul_step = {pmul_reg[PMUL_W-2:0], 1'b0}
                  + (mplier_reg[MAG_W-1] ? {{MAG_W{1'b0}}, period_reg} : '0);
        trial     = {rem_reg, div_lo_reg[QSAT_BITS-1]} - {1'b0, span_mag_reg};
        fill_sum  = neg_reg
                  ? $signed({{(SUM_W-VAL_W){pv_reg[VAL_W-1]}}, pv_reg})
                    - $signed({{(SUM_W-Q_W){1'b0}}, q_reg})
                  : $signed({{(SUM_W-VAL_W){pv_reg[VAL_W-1]}}, pv_reg})
                    + $signed({{(SUM_W-Q_W){1'b0}}, q_reg});
        if (fill_sum > $signed(SUM_W'({1'b0, {(VAL_W-1){1'b1}}}))) begin
            fill_val = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (fill_sum < -$signed(SUM_W'({1'b1, {(VAL_W-1){1'b0}}}))) begin
            fill_val = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            fill_val = fill_sum[VAL_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        t_next          = t_reg;
        v_next          = v_reg;
        pt_next         = pt_reg;
        pv_next         = pv_reg;
        have_prev_next  = have_prev_reg;
        d_next          = d_reg;
        fill_total_next = fill_total_reg;
        fill_idx_next   = fill_idx_reg;
        status_next     = status_reg;
        gtime_next      = gtime_reg;
        span_mag_next   = span_mag_reg;
        span_zero_next  = span_zero_reg;
        neg_next        = neg_reg;
        mplier_next     = mplier_reg;
        pmul_next       = pmul_reg;
        prod_next       = prod_reg;
        rem_next        = rem_reg;
        div_lo_next     = div_lo_reg;
        q_next          = q_reg;
        step_next       = step_reg;
        out_load        = 1'b0;
        m_data_next     = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    t_next      = s_data.sample_time;
                    v_next      = s_data.sample_value;
                    status_next = STAT_OK;
                    if (s_data.restart || !have_prev_reg) begin
                        state_next = ST_LAST;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                d_next         = d_acc;
                span_zero_next = (span_s == '0);
                span_mag_next  = span_s[DIFF_W-1] ? TIME_W'(-span_s) : span_s[TIME_W-1:0];
                neg_next       = dv[VAL_W] ^ span_s[DIFF_W-1];
                mplier_next    = dv[VAL_W] ? MAG_W'(-dv) : dv[MAG_W-1:0];
                gtime_next     = pt_reg + period_reg;
                fill_total_next = '0;
                fill_idx_next   = '0;
                state_next      = ST_GAP;
            end
            ST_GAP: begin
                if (d_reg > tol_s || -d_reg > tol_s) begin
                    state_next = ST_COUNT;
                end else begin
                    state_next = ST_LAST;
                end
            end
            ST_COUNT: begin
                // one fill per cycle until the offset is not above tol or at MAX_FILL
                d_next          = dn;
                fill_total_next = fill_total_reg + 1'b1;
                if (!(dn > tol_s && fill_total_next < CNT_W'(MAX_FILL))) begin
                    if (dn > tol_s) begin
                        status_next = STAT_LIMIT;
                    end else if (-dn > tol_s) begin
                        status_next = STAT_UNEVEN;
                    end else begin
                        status_next = STAT_OK;
                    end
                    pmul_next = '0;
                    step_next = '0;
                    state_next = use_div ? ST_MUL : ST_FILL_OUT;
                end
            end
            ST_MUL: begin
                // |dv| * period, MSB first
                pmul_next   = pmul_step;
                mplier_next = {mplier_reg[MAG_W-2:0], 1'b0};
                step_next   = step_reg + 1'b1;
                if (step_reg == CNT_W'(MAG_W - 1)) begin
                    prod_next  = {{(PROD_W-PMUL_W){1'b0}}, pmul_step};
                    state_next = ST_SAT;
                end
            end
            ST_SAT: begin
                if (prod_reg >= {{(PROD_W-TIME_W-QSAT_BITS){1'b0}}, span_mag_reg,
                                 {QSAT_BITS{1'b0}}}) begin
                    q_next     = {1'b1, {QSAT_BITS{1'b0}}};
                    state_next = ST_FILL_OUT;
                end else begin
                    rem_next    = prod_reg[QSAT_BITS+TIME_W-1:QSAT_BITS];
                    div_lo_next = prod_reg[QSAT_BITS-1:0];
                    q_next      = '0;
                    step_next   = '0;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!trial[TIME_W]) begin
                    rem_next = trial[TIME_W-1:0];
                end else begin
                    rem_next = {rem_reg[TIME_W-2:0], div_lo_reg[QSAT_BITS-1]};
                end
                q_next      = {q_reg[Q_W-2:0], !trial[TIME_W]};
                div_lo_next = {div_lo_reg[QSAT_BITS-2:0], 1'b0};
                step_next   = step_reg + 1'b1;
                if (step_reg == CNT_W'(QSAT_BITS - 1)) begin
                    state_next = ST_FILL_OUT;
                end
            end
            ST_FILL_OUT: begin
                if (slot_free) begin
                    out_load             = 1'b1;
                    m_data_next.out_time = gtime_reg;
                    m_data_next.status   = status_reg;
                    m_data_next.last     = 1'b0;
                    if (!interp_reg) begin
                        m_data_next.out_value = '0;
                        m_data_next.fill_kind = FILL_MISSING;
                    end else begin
                        m_data_next.out_value = span_zero_reg ? pv_reg : fill_val;
                        m_data_next.fill_kind = FILL_INTERP;
                    end
                    fill_idx_next = fill_idx_reg + 1'b1;
                    gtime_next    = gtime_reg + period_reg;
                    prod_next     = prod_reg + {{(PROD_W-PMUL_W){1'b0}}, pmul_reg};
                    if (fill_idx_next == fill_total_reg) begin
                        state_next = ST_LAST;
                    end else if (use_div) begin
                        state_next = ST_SAT;
                    end
                end
            end
            ST_LAST: begin
                if (slot_free) begin
                    out_load              = 1'b1;
                    m_data_next.out_time  = t_reg;
                    m_data_next.out_value = v_reg;
                    m_data_next.fill_kind = FILL_ORIG;
                    m_data_next.status    = status_reg;
                    m_data_next.last      = 1'b1;
                    pt_next               = t_reg;
                    pv_next               = v_reg;
                    have_prev_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    `TSGF_ASSERT_IMP(a_div_rem_below_span, state_reg == ST_DIV, rem_reg < span_mag_reg, "divider remainder not below span")
    `TSGF_ASSERT_IMP(a_fill_idx_in_run, state_reg == ST_FILL_OUT, fill_idx_reg < fill_total_reg, "fill index past run length")
    `TSGF_ASSERT_IMP(a_fill_total_limit, state_reg == ST_FILL_OUT, fill_total_reg <= CNT_W'(MAX_FILL), "fill run above limit")
    `TSGF_ASSERT_IMP(a_orig_is_last, m_valid_reg && m_data_reg.fill_kind == FILL_ORIG, m_data_reg.last, "original sample not marked last")
    `TSGF_ASSERT_NXT(a_last_frees_input, out_load && m_data_next.last, state_reg == ST_IDLE, "block not idle after final transfer")

endmodule
